// ===== rtl/tvrp_pkg.sv =====
// ============================================================================
// tvrp_pkg: shared types and constants of the tile video register port
// Holds the transaction structs, command and register codes, and the sizes
// of the internal stores.
// ============================================================================
package tvrp_pkg;

    // Store sizes
    localparam int SPR_DEPTH   = 256;
    localparam int SPR_ADDR_W  = 8;
    localparam int NT_DEPTH    = 2048;
    localparam int NT_ADDR_W   = 11;
    localparam int PAL_DEPTH   = 32;
    localparam int PAL_ADDR_W  = 5;
    localparam int PTR_W       = 15;

    // Address space boundaries (14-bit video address)
    localparam logic [13:0] PAL_BASE  = 14'h3F00;
    localparam logic [13:0] NT_BASE   = 14'h2000;

    // Commands
    localparam logic [2:0] CMD_REG_READ  = 3'd0;
    localparam logic [2:0] CMD_REG_WRITE = 3'd1;
    localparam logic [2:0] CMD_VBLANK    = 3'd2;
    localparam logic [2:0] CMD_PRERENDER = 3'd3;
    localparam logic [2:0] CMD_SPR0_HIT  = 3'd4;
    localparam logic [2:0] CMD_OVERFLOW  = 3'd5;

    // Register indexes
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_SPR_ADDR = 3'd3;
    localparam logic [2:0] REG_SPR_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Mirroring modes
    localparam logic [1:0] MIRROR_HORZ = 2'd0;

    // Input transaction
    typedef struct packed {
        logic [2:0] command;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] chr_read_data;
        logic       rendering_active;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_request;
        logic [12:0] chr_addr;
        logic        chr_read;
        logic        chr_write;
        logic [7:0]  chr_write_data;
    } result_t;

    // Store write requests from the execute logic
    typedef struct packed {
        logic       nt_we;
        logic       spr_we;
        logic [7:0] wdata;
    } mem_wr_t;

endpackage

// ===== rtl/tvrp_nt_mem.sv =====
// ============================================================================
// tvrp_nt_mem: name-table RAM
// Single-port synchronous RAM with a registered read. After reset a clearing
// pass writes zero to every entry, one per cycle.
// ============================================================================
module tvrp_nt_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tvrp_pkg::NT_ADDR_W-1:0] addr,
    input  logic                          we,
    input  logic [7:0]                    wdata,
    output logic [7:0]                    rdata,
    output logic                          clearing
);

    logic [7:0]                    mem [tvrp_pkg::NT_DEPTH];
    logic [7:0]                    rdata_reg;
    logic                          clr_active_reg;
    logic [tvrp_pkg::NT_ADDR_W-1:0] clr_cnt_reg;

    // Clearing sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + tvrp_pkg::NT_ADDR_W'(1);
            if (clr_cnt_reg == {tvrp_pkg::NT_ADDR_W{1'b1}})
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Memory array with registered read
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_cnt_reg] <= 8'h00;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_active_reg;

endmodule

// ===== rtl/tvrp_spr_mem.sv =====
// ============================================================================
// tvrp_spr_mem: sprite memory
// Synchronous RAM with a registered read and one valid bit per entry; an
// entry never written since reset reads as 0xFF.
// ============================================================================
module tvrp_spr_mem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tvrp_pkg::SPR_ADDR_W-1:0] addr,
    input  logic                           we,
    input  logic [7:0]                     wdata,
    output logic [7:0]                     rdata
);

    logic [7:0]                   mem [tvrp_pkg::SPR_DEPTH];
    logic [tvrp_pkg::SPR_DEPTH-1:0] valid_reg;
    logic [7:0]                   rdata_reg;
    logic                         rvalid_reg;

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[addr];
        end
    end

    // Memory array with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'hFF;

endmodule

// ===== rtl/tvrp_core.sv =====
// ============================================================================
// tvrp_core: register file and execute logic
// Holds the CPU-visible registers, pointers, palette and read buffer,
// executes one transaction per execute cycle and registers its result.
// ============================================================================
module tvrp_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tvrp_pkg::item_t                item,
    input  logic                           exec,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_data,
    input  logic [7:0]                     nt_rdata,
    input  logic [7:0]                     spr_rdata,
    output logic [tvrp_pkg::NT_ADDR_W-1:0]  nt_addr,
    output logic [tvrp_pkg::SPR_ADDR_W-1:0] spr_addr,
    output tvrp_pkg::mem_wr_t              mem_wr,
    output tvrp_pkg::result_t              result,
    output logic                           done
);

    // State registers
    logic [1:0]                mirror_reg;
    logic [7:0]                ctrl_reg,    ctrl_next;
    logic [7:0]                mask_reg,    mask_next;
    logic [2:0]                status_reg,  status_next;
    logic [7:0]                spr_ptr_reg, spr_ptr_next;
    logic [tvrp_pkg::PTR_W-1:0] cur_reg,     cur_next;
    logic [tvrp_pkg::PTR_W-1:0] tmp_reg,     tmp_next;
    logic [2:0]                fine_x_reg,  fine_x_next;
    logic                      toggle_reg,  toggle_next;
    logic [7:0]                rbuf_reg,    rbuf_next;
    logic [7:0]                pal_reg [tvrp_pkg::PAL_DEPTH];
    tvrp_pkg::result_t         result_reg,  result_next;
    logic                      done_reg;

    logic [13:0]                 vaddr;
    logic [tvrp_pkg::PAL_ADDR_W-1:0] pal_idx;
    logic                        pal_we;
    logic [7:0]                  pal_byte;
    logic [tvrp_pkg::PTR_W-1:0]   cur_step;

    // Address decode: name-table mirroring and palette folding
    assign vaddr   = cur_reg[13:0];
    assign nt_addr = (mirror_reg == tvrp_pkg::MIRROR_HORZ)
                   ? {vaddr[11], vaddr[9:0]} : vaddr[10:0];
    assign pal_idx = (vaddr[4] && (vaddr[1:0] == 2'b00))
                   ? {1'b0, vaddr[3:0]} : vaddr[4:0];
    assign pal_byte = pal_reg[pal_idx];
    assign cur_step = ctrl_reg[2] ? tvrp_pkg::PTR_W'(32) : tvrp_pkg::PTR_W'(1);
    assign spr_addr = spr_ptr_reg;

    // Execute logic
    always_comb
    begin
        ctrl_next    = ctrl_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        spr_ptr_next = spr_ptr_reg;
        cur_next     = cur_reg;
        tmp_next     = tmp_reg;
        fine_x_next  = fine_x_reg;
        toggle_next  = toggle_reg;
        rbuf_next    = rbuf_reg;
        result_next  = '0;
        mem_wr       = '0;
        mem_wr.wdata = item.write_data;
        pal_we       = 1'b0;

        if (exec)
        begin
            case (item.command)
                tvrp_pkg::CMD_REG_READ:
                begin
                    case (item.reg_index)
                        tvrp_pkg::REG_STATUS:
                        begin
                            result_next.read_data = {status_reg, 5'b00000};
                            status_next[2]        = 1'b0;
                            toggle_next           = 1'b0;
                        end
                        tvrp_pkg::REG_SPR_DATA:
                        begin
                            result_next.read_data = spr_rdata;
                        end
                        tvrp_pkg::REG_DATA:
                        begin
                            if (vaddr >= tvrp_pkg::PAL_BASE)
                            begin
                                result_next.read_data = mask_reg[0]
                                                      ? (pal_byte & 8'h30) : pal_byte;
                                rbuf_next = nt_rdata;
                            end
                            else
                            begin
                                result_next.read_data = rbuf_reg;
                                if (vaddr < tvrp_pkg::NT_BASE)
                                begin
                                    result_next.chr_read = 1'b1;
                                    result_next.chr_addr = vaddr[12:0];
                                    rbuf_next            = item.chr_read_data;
                                end
                                else
                                begin
                                    rbuf_next = nt_rdata;
                                end
                            end
                            cur_next = cur_reg + cur_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                tvrp_pkg::CMD_REG_WRITE:
                begin
                    case (item.reg_index)
                        tvrp_pkg::REG_CTRL:
                        begin
                            result_next.nmi_request = !ctrl_reg[7] && item.write_data[7]
                                                    && status_reg[2];
                            ctrl_next       = item.write_data;
                            tmp_next[11:10] = item.write_data[1:0];
                        end
                        tvrp_pkg::REG_MASK:
                        begin
                            mask_next = item.write_data;
                        end
                        tvrp_pkg::REG_SPR_ADDR:
                        begin
                            spr_ptr_next = item.write_data;
                        end
                        tvrp_pkg::REG_SPR_DATA:
                        begin
                            // Writes are dropped while rendering is on.
                            if (!(item.rendering_active && (mask_reg[3] || mask_reg[4])))
                            begin
                                mem_wr.spr_we = 1'b1;
                                spr_ptr_next  = spr_ptr_reg + 8'd1;
                            end
                        end
                        tvrp_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                fine_x_next   = item.write_data[2:0];
                                tmp_next[4:0] = item.write_data[7:3];
                            end
                            else
                            begin
                                tmp_next[9:5]   = item.write_data[7:3];
                                tmp_next[14:12] = item.write_data[2:0];
                            end
                            toggle_next = !toggle_reg;
                        end
                        tvrp_pkg::REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_next[14]   = 1'b0;
                                tmp_next[13:8] = item.write_data[5:0];
                            end
                            else
                            begin
                                tmp_next[7:0] = item.write_data;
                                cur_next      = {tmp_reg[14:8], item.write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        tvrp_pkg::REG_DATA:
                        begin
                            if (vaddr < tvrp_pkg::NT_BASE)
                            begin
                                result_next.chr_write      = 1'b1;
                                result_next.chr_addr       = vaddr[12:0];
                                result_next.chr_write_data = item.write_data;
                            end
                            else if (vaddr < tvrp_pkg::PAL_BASE)
                            begin
                                mem_wr.nt_we = 1'b1;
                            end
                            else
                            begin
                                pal_we = 1'b1;
                            end
                            cur_next = cur_reg + cur_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                tvrp_pkg::CMD_VBLANK:
                begin
                    status_next[2]          = 1'b1;
                    result_next.nmi_request = ctrl_reg[7];
                end
                tvrp_pkg::CMD_PRERENDER:
                begin
                    status_next = 3'b000;
                end
                tvrp_pkg::CMD_SPR0_HIT:
                begin
                    status_next[1] = 1'b1;
                end
                tvrp_pkg::CMD_OVERFLOW:
                begin
                    status_next[0] = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg  <= '0;
            ctrl_reg    <= '0;
            mask_reg    <= '0;
            status_reg  <= '0;
            spr_ptr_reg <= '0;
            cur_reg     <= '0;
            tmp_reg     <= '0;
            fine_x_reg  <= '0;
            toggle_reg  <= 1'b0;
            rbuf_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mirror_reg <= cfg_data;
            end
            ctrl_reg    <= ctrl_next;
            mask_reg    <= mask_next;
            status_reg  <= status_next;
            spr_ptr_reg <= spr_ptr_next;
            cur_reg     <= cur_next;
            tmp_reg     <= tmp_next;
            fine_x_reg  <= fine_x_next;
            toggle_reg  <= toggle_next;
            rbuf_reg    <= rbuf_next;
            done_reg    <= exec;
        end
    end

    // Palette RAM, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tvrp_pkg::PAL_DEPTH; i++)
            begin
                pal_reg[i] <= 8'h00;
            end
        end
        else if (pal_we)
        begin
            pal_reg[pal_idx] <= item.write_data;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/tile_video_register_port_unit.sv =====
// ============================================================================
// tile_video_register_port_unit: CPU register port of a tile video chip
// Control, mask, status, sprite, scroll, address and data registers with
// internal name-table, palette and sprite memories.
// ============================================================================
//
//   Channel   Signals                        Transaction
//   --------  -----------------------------  -------------------------------
//   command   start, busy, item              taken when start & !busy
//   result    done, result                   one cycle, marked by done
//   config    cfg_valid, cfg_ready, cfg_data taken when cfg_valid & cfg_ready
//
// A command passes through a read cycle for the name-table and sprite RAM
// ports, then an execute cycle that updates state and loads the result
// register; done rises the cycle after. A new command can be taken in the
// execute cycle of the command before it.
// After reset, busy stays high while the 2048-entry name-table RAM is cleared,
// one entry per cycle. The receiver cannot stall results.
//
module tile_video_register_port_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tvrp_pkg::item_t   item,
    output logic              done,
    output tvrp_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);

    tvrp_pkg::item_t                item_reg;
    logic                           rd_phase_reg;
    logic                           exec_reg;
    logic                           accept;
    logic                           nt_clearing;
    logic [7:0]                     nt_rdata;
    logic [7:0]                     spr_rdata;
    logic [tvrp_pkg::NT_ADDR_W-1:0]  nt_addr;
    logic [tvrp_pkg::SPR_ADDR_W-1:0] spr_addr;
    tvrp_pkg::mem_wr_t              mem_wr;

    // Command handshake and phase tracking
    assign busy      = rd_phase_reg || nt_clearing;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_phase_reg <= 1'b0;
            exec_reg     <= 1'b0;
        end
        else
        begin
            rd_phase_reg <= accept;
            exec_reg     <= rd_phase_reg;
        end
    end

    // Command register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    tvrp_nt_mem u_nt_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (nt_addr),
        .we       (mem_wr.nt_we),
        .wdata    (mem_wr.wdata),
        .rdata    (nt_rdata),
        .clearing (nt_clearing)
    );

    tvrp_spr_mem u_spr_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (spr_addr),
        .we    (mem_wr.spr_we),
        .wdata (mem_wr.wdata),
        .rdata (spr_rdata)
    );

    tvrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_reg),
        .exec      (exec_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .nt_rdata  (nt_rdata),
        .spr_rdata (spr_rdata),
        .nt_addr   (nt_addr),
        .spr_addr  (spr_addr),
        .mem_wr    (mem_wr),
        .result    (result),
        .done      (done)
    );

    // A read cycle is always followed by an execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_phase_reg |=> exec_reg)
        else $error("read cycle not followed by execute cycle");

    // Only one command is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_phase_reg && exec_reg))
        else $error("two commands in flight");

    // No command executes while the name-table RAM is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_reg |-> !nt_clearing)
        else $error("command executed during name-table clear");

    // A result never fetches and writes pattern memory at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.chr_read && result.chr_write))
        else $error("pattern read and write in one result");

endmodule
